// ===== rtl/core/humidity_temperature_frame_decoder_core_assert.svh =====
// Assertion macros shared by the frame decoder RTL.
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HTFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame decoder assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame decoder assertion failed");

`endif

// ===== rtl/core/htfd_pkg.sv =====
// Types, constants and the CRC-8 byte update shared by the frame decoder.
package htfd_pkg;

    // Status byte check: busy bit clear and both ready bits set.
    localparam logic [7:0] STATUS_MASK  = 8'h98;
    localparam logic [7:0] STATUS_READY = 8'h18;

    // CRC-8, polynomial 0x31, seed 0xFF, MSB first, no final XOR.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion scales applied to the 20-bit raw codes.
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [9:0]  HUM_SCALE   = 10'd1000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    // Plausible temperature window, expressed on the scaled code before the
    // offset is removed (-4000 + 5000 and 8500 + 5000).
    localparam logic [14:0] SCALED_MIN = 15'd1000;
    localparam logic [14:0] SCALED_MAX = 15'd13500;

    // Result codes.
    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_STATUS = 2'd1,
        ERR_CRC    = 2'd2,
        ERR_RANGE  = 2'd3
    } t_err;

    // Advances the CRC by one data byte, one bit per step.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/htfd_crc3.sv =====
// Advances the CRC-8 over three frame bytes, most significant byte first.
module htfd_crc3 (
    input  logic [7:0]  i_crc,
    input  logic [23:0] i_bytes,
    output logic [7:0]  o_crc
);

    logic [7:0] crc_1;
    logic [7:0] crc_2;

    // Three chained byte updates.
    always_comb begin
        crc_1 = htfd_pkg::crc8_byte(i_crc, i_bytes[23:16]);
        crc_2 = htfd_pkg::crc8_byte(crc_1, i_bytes[15:8]);
        o_crc = htfd_pkg::crc8_byte(crc_2, i_bytes[7:0]);
    end

endmodule

// ===== rtl/core/humidity_temperature_frame_decoder_core.sv =====
// Top level of the humidity and temperature response frame decoder.
//
// Takes one 7-byte sensor response frame per item and returns one decoded
// result per item: temperature in hundredths of a degree, humidity in tenths
// of a percent, a valid flag and an error code (status fault, CRC mismatch or
// temperature out of range). The block is a four-stage pipeline (input
// register, status check and CRC over bytes 0..2, CRC over bytes 3..5 with the
// two constant multiplies, then offset, range check and the output register),
// so a new item can be taken in every cycle while the output is not stalled.
// An output stall holds every occupied stage in place while empty stages still
// fill, so the input keeps accepting items until all four stages are full.
module humidity_temperature_frame_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [55:0]        i_frame,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_temperature_centi_c,
    output logic [9:0]         o_humidity_tenths_pct,
    output logic               o_sample_valid,
    output logic [1:0]         o_error_code
);

    `include "humidity_temperature_frame_decoder_core_assert.svh"

    // Stage valid bits.
    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;
    logic r_d_valid;

    // Per-stage advance enables.
    logic adv_a;
    logic adv_b;
    logic adv_c;
    logic adv_d;

    // Stage A: captured frame.
    logic [55:0] r_a_frame;

    // Stage B: status check and first half of the CRC.
    logic [7:0]  n_b_crc;
    logic [7:0]  r_b_crc;
    logic        r_b_status_ok;
    logic [19:0] r_b_raw_h;
    logic [31:0] r_b_low;

    // Stage C: CRC result and scaled products.
    logic [7:0]       n_c_crc;
    htfd_pkg::t_err   n_c_err;
    htfd_pkg::t_err   r_c_err;
    logic [34:0]      r_c_prod_t;
    logic [29:0]      r_c_prod_h;

    // Stage D: output register.
    logic [14:0]      c_scaled_t;
    logic             c_in_range;
    logic [14:0]      n_d_temp;
    logic [9:0]       n_d_hum;
    logic             n_d_valid_flag;
    htfd_pkg::t_err   n_d_err;
    logic [14:0]      r_d_temp;
    logic [9:0]       r_d_hum;
    logic             r_d_valid_flag;
    htfd_pkg::t_err   r_d_err;

    // Shorthand terms for the checks at the end.
    logic chk_flag_ok;
    logic chk_rejected;
    logic chk_zero_vals;
    logic chk_out_blocked;

    // A stage moves when it is empty or the stage after it moves.
    assign adv_d      = !r_d_valid || i_out_ready;
    assign adv_c      = !r_c_valid || adv_d;
    assign adv_b      = !r_b_valid || adv_c;
    assign adv_a      = !r_a_valid || adv_b;
    assign o_in_ready = adv_a;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (adv_a) r_a_valid <= i_in_valid;
            if (adv_b) r_b_valid <= r_a_valid;
            if (adv_c) r_c_valid <= r_b_valid;
            if (adv_d) r_d_valid <= r_c_valid;
        end
    end

    // Stage A: register the incoming frame.
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_frame <= i_frame;
        end
    end

    // Stage B: CRC over the status byte and the next two bytes.
    htfd_crc3 u_crc_hi (
        .i_crc   (htfd_pkg::CRC_INIT),
        .i_bytes (r_a_frame[55:32]),
        .o_crc   (n_b_crc)
    );

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b_crc       <= n_b_crc;
            r_b_status_ok <= (r_a_frame[55:48] & htfd_pkg::STATUS_MASK)
                             == htfd_pkg::STATUS_READY;
            r_b_raw_h     <= r_a_frame[47:28];
            r_b_low       <= r_a_frame[31:0];
        end
    end

    // Stage C: finish the CRC over bytes three to five and compare.
    htfd_crc3 u_crc_lo (
        .i_crc   (r_b_crc),
        .i_bytes (r_b_low[31:8]),
        .o_crc   (n_c_crc)
    );

    // The status fault takes precedence over a CRC mismatch.
    always_comb begin
        if (!r_b_status_ok) begin
            n_c_err = htfd_pkg::ERR_STATUS;
        end else if (n_c_crc != r_b_low[7:0]) begin
            n_c_err = htfd_pkg::ERR_CRC;
        end else begin
            n_c_err = htfd_pkg::ERR_OK;
        end
    end

    // Constant multiplies on the raw codes.
    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_c_err    <= n_c_err;
            r_c_prod_t <= 35'(r_b_low[27:8]) * 35'(htfd_pkg::TEMP_SCALE);
            r_c_prod_h <= 30'(r_b_raw_h) * 30'(htfd_pkg::HUM_SCALE);
        end
    end

    // Stage D: remove the offset, check the window, zero rejected frames.
    assign c_scaled_t = r_c_prod_t[34:20];
    assign c_in_range = (c_scaled_t >= htfd_pkg::SCALED_MIN)
                     && (c_scaled_t <= htfd_pkg::SCALED_MAX);

    always_comb begin
        n_d_temp       = '0;
        n_d_hum        = '0;
        n_d_valid_flag = 1'b0;
        n_d_err        = r_c_err;
        if (r_c_err == htfd_pkg::ERR_OK) begin
            n_d_temp = c_scaled_t - htfd_pkg::TEMP_OFFSET;
            n_d_hum  = r_c_prod_h[29:20];
            if (c_in_range) begin
                n_d_valid_flag = 1'b1;
            end else begin
                n_d_err = htfd_pkg::ERR_RANGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_d) begin
            r_d_temp       <= n_d_temp;
            r_d_hum        <= n_d_hum;
            r_d_valid_flag <= n_d_valid_flag;
            r_d_err        <= n_d_err;
        end
    end

    // Output ports.
    assign o_out_valid           = r_d_valid;
    assign o_temperature_centi_c = $signed(r_d_temp);
    assign o_humidity_tenths_pct = r_d_hum;
    assign o_sample_valid        = r_d_valid_flag;
    assign o_error_code          = r_d_err;

    // Terms used by the checks below.
    assign chk_flag_ok     = (r_d_valid_flag == (r_d_err == htfd_pkg::ERR_OK));
    assign chk_rejected    = r_d_valid && ((r_d_err == htfd_pkg::ERR_STATUS)
                                        || (r_d_err == htfd_pkg::ERR_CRC));
    assign chk_zero_vals   = (r_d_temp == '0) && (r_d_hum == '0);
    assign chk_out_blocked = r_d_valid && !i_out_ready;

    // The flag and the error code must agree on every delivered item.
    `HTFD_ASSERT_IMPLIES(a_flag_matches_code, i_clk, i_rst_n, r_d_valid, chk_flag_ok)
    // Rejected frames carry zero values.
    `HTFD_ASSERT_IMPLIES(a_reject_zero, i_clk, i_rst_n, chk_rejected, chk_zero_vals)
    // The input side only stalls when a finished item waits at the output.
    `HTFD_ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready, chk_out_blocked)
    // An accepted item always lands in the first stage.
    `HTFD_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, i_in_valid && o_in_ready, r_a_valid)

endmodule
